### rtl/core/fp8e4_pkg.sv
// Package: opcodes, decode/encode helpers for the FP8 E4M3 unit.
`default_nettype none
package fp8e4_pkg;
    localparam logic [2:0] OP_MUL     = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_MUL_F32 = 3'd2;
    localparam logic [2:0] OP_TO_F16  = 3'd3;
    localparam logic [2:0] OP_ENCODE  = 3'd4;
    localparam logic [2:0] OP_DECODE  = 3'd5;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [31:0] float_in;
    } req_t;

    // fp8 to binary32; NaN decodes to +0
    function automatic logic [31:0] dec8(input logic [7:0] v);
        logic [3:0] e;
        logic [2:0] m;
        logic [31:0] r;
        e = v[6:3];
        m = v[2:0];
        r = 32'd0;
        if (e == 4'hF) begin
            r = 32'd0;
        end else if (e == 4'd0) begin
            // subnormal m * 2^-9, renormalized
            if (m[2]) r = {1'b0, 8'd120, m[1:0], 21'd0};
            else if (m[1]) r = {1'b0, 8'd119, m[0], 22'd0};
            else if (m[0]) r = {1'b0, 8'd118, 23'd0};
            else r = 32'd0;
            r[31] = v[7];
        end else begin
            r = {v[7], 4'd0, e, m, 20'd0} + {1'b0, 8'd120, 23'd0};
        end
        return r;
    endfunction

    // binary32 to fp8, RNE, saturating
    function automatic logic [7:0] enc8(input logic [31:0] x);
        logic [7:0] sign;
        logic [7:0] be;
        logic [23:0] m;
        logic [4:0] sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        logic [7:0] code;
        logic [8:0] sum;
        sign = x[31] ? 8'h80 : 8'h00;
        be = x[30:23];
        m = {1'b1, x[22:0]};
        sh = (be >= 8'd121) ? 5'd20 : 5'(8'd141 - be);
        q = m >> sh;
        rem = m & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        if (rem > half || (rem == half && q[0])) q = q + 24'd1;
        if (be >= 8'd121) sum = 9'(be - 8'd121) * 9'd8 + 9'(q[4:0]);
        else sum = 9'(q[4:0]);
        code = (sum > 9'h77) ? 8'h77 : sum[7:0];
        if (be == 8'hFF || x[30:0] == 31'd0) return 8'h00;
        if (x[30:0] >= 31'h43700000) return sign | 8'h77;
        if (be < 8'd117) return sign;
        return sign | code;
    endfunction

    function automatic logic [15:0] to_f16(input logic [7:0] v);
        logic [3:0] e;
        logic [2:0] m;
        e = v[6:3];
        m = v[2:0];
        if (e == 4'd0 && m == 3'd0) return {v[7], 15'd0};
        if (e == 4'hF) return {v[7], 5'd31, 10'd1};
        if (e == 4'd0) begin
            if (m[2]) return {v[7], 5'd8, m[1:0], 8'd0};
            if (m[1]) return {v[7], 5'd7, m[0], 9'd0};
            return {v[7], 5'd6, 10'd0};
        end
        return {v[7], 5'(e) + 5'd8, m, 7'd0};
    endfunction
endpackage
`default_nettype wire

### rtl/core/fp8e4_arith.sv
// Combinational datapath: exact fp8 multiply/add on decoded values, conversions.
`default_nettype none
module fp8e4_arith (
    input  wire fp8e4_pkg::req_t req,
    output logic [31:0]          result
);
    import fp8e4_pkg::*;
    logic [31:0] fa, fb;
    // exact product on 4-bit significands
    logic [3:0] sa, sb;
    logic [7:0] sp;
    logic signed [9:0] ea, eb, ep;
    logic [31:0] prod;
    // exact sum in fixed point, quantum 2^-9, |x| < 2^9
    logic signed [19:0] xa, xb, xs;
    logic [18:0] mag;
    logic [4:0] msb;
    logic [31:0] sumf;
    logic [22:0] frac;

    function automatic logic signed [19:0] fx(input logic [7:0] v);
        logic [18:0] u;
        if (v[6:3] == 4'hF) return 20'sd0;
        if (v[6:3] == 4'd0) u = 19'(v[2:0]);
        else u = 19'({1'b1, v[2:0]}) << (v[6:3] - 4'd1);
        return v[7] ? -$signed({1'b0, u}) : $signed({1'b0, u});
    endfunction

    always_comb begin
        fa = dec8(req.operand_a);
        fb = dec8(req.operand_b);
        sa = (fa[30:0] == 31'd0) ? 4'd0 : {1'b1, fa[22:20]};
        sb = (fb[30:0] == 31'd0) ? 4'd0 : {1'b1, fb[22:20]};
        ea = 10'(fa[30:23]);
        eb = 10'(fb[30:23]);
        sp = sa * sb;
        prod = 32'd0;
        if (sp != 8'd0) begin
            if (sp[7]) begin
                ep = ea + eb - 10'sd126;
                prod = {1'b0, ep[7:0], sp[6:0], 16'd0};
            end else begin
                ep = ea + eb - 10'sd127;
                prod = {1'b0, ep[7:0], sp[5:0], 17'd0};
            end
        end else begin
            ep = 10'sd0;
        end
        prod[31] = fa[31] ^ fb[31];
        xa = fx(req.operand_a);
        xb = fx(req.operand_b);
        xs = xa + xb;
        mag = xs[19] ? 19'(-xs) : xs[18:0];
        msb = 5'd0;
        for (int i = 0; i < 19; i++) if (mag[i]) msb = 5'(i);
        frac = 23'({mag, 23'd0} >> msb);
        sumf = (mag == 19'd0) ? 32'd0
             : {xs[19], 8'(8'd118 + 8'(msb)), frac};
        unique case (req.opcode)
            OP_MUL:     result = {24'd0, enc8(prod)};
            OP_ADD:     result = {24'd0, enc8(sumf)};
            OP_MUL_F32: result = prod;
            OP_TO_F16:  result = {16'd0, to_f16(req.operand_a)};
            OP_ENCODE:  result = {24'd0, enc8(req.float_in)};
            OP_DECODE:  result = fa;
            default:    result = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/fp8_e4m3_arith_convert_unit_core.sv
// Top level: FP8 E4M3 arithmetic and conversion unit with registered I/O.
// Path: the request is captured in the input register, passes the combinational datapath, and its
// result is captured in the result register, which drives m_valid and m_result.
// Throughput: one request per cycle, set by the single-pass datapath between the two
// registers; a stalled result holds both registers and drops s_ready once both are full.
// Reset: aresetn synchronous active low clears both valid flags; payload is not reset.
`default_nettype none
module fp8_e4m3_arith_convert_unit_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [2:0]   s_opcode,
    input  wire [7:0]   s_operand_a,
    input  wire [7:0]   s_operand_b,
    input  wire [31:0]  s_float_in,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_result
);
    import fp8e4_pkg::*;
    req_t        req_reg;
    logic        in_vld_reg;
    logic [31:0] res_comb;
    logic        adv;

    // stage 2 advances when result slot is empty or being drained
    assign adv     = !m_valid || m_ready;
    assign s_ready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            if (s_ready) in_vld_reg <= s_valid;
            if (adv) m_valid <= in_vld_reg;
        end
        if (s_ready && s_valid) begin
            req_reg <= '{s_opcode, s_operand_a, s_operand_b, s_float_in};
        end
        if (adv && in_vld_reg) m_result <= res_comb;
    end

    fp8e4_arith u_arith (
        .req    (req_reg),
        .result (res_comb)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed while stalled");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && adv |=> m_valid)
        else $error("request lost between stages");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("stalled while empty");
endmodule
`default_nettype wire

### tb/sv/tb_fp8_e4m3_arith_convert_unit_core.sv
// Testbench for the FP8 E4M3 arithmetic and conversion unit: random bursts against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_fp8_e4m3_arith_convert_unit_core;
    import fp8e4_pkg::*;

    localparam int IDLE_LIMIT = 4000;   // cycles with no accepted request on either side
    localparam int RANDOM_REQS = 650;

    // unused opcodes, named locally since the package stops at decode
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_opcode;
    logic [7:0]  s_operand_a;
    logic [7:0]  s_operand_b;
    logic [31:0] s_float_in;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result;

    fp8_e4m3_arith_convert_unit_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_float_in  (s_float_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    req_t        pending_reqs[$];    // requests waiting to be driven
    logic [31:0] expected_results[$]; // predicted results, oldest first
    int          err_cnt = 0;
    int          idle_cycles = 0;
    bit          req_taken = 1'b0;    // request accepted at the last rising edge
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_phase = 0;

    // ------------------------------------------------------------------
    // Predictor. FP8 values are held as signed integers scaled by 2^9, so
    // products (scale 2^18) and sums (scale 2^9) are exact.
    // ------------------------------------------------------------------

    // magnitude of an fp8 code in units of 2^-9; NaN reads as +0
    function automatic longint unsigned fp8_units(input logic [7:0] v);
        logic [3:0] e;
        logic [2:0] m;
        e = v[6:3];
        m = v[2:0];
        if (e == 4'hF) return 0;
        if (e == 4'd0) return longint'(m);
        return longint'({1'b1, m}) << (e - 1);
    endfunction

    function automatic bit fp8_neg(input logic [7:0] v);
        return v[7] && v[6:3] != 4'hF;
    endfunction

    // exact binary32 pattern for (-1)^neg * mag * 2^-scale
    function automatic logic [31:0] units_to_f32(input bit neg, input longint unsigned mag,
                                                 input int scale);
        int          msb;
        logic [63:0] frac;
        if (mag == 0) return {neg, 31'd0};
        msb = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
        frac = (msb <= 23) ? (mag << (23 - msb)) : (mag >> (msb - 23));
        return {neg, 8'(msb - scale + 127), frac[22:0]};
    endfunction

    // binary32 to fp8: saturating, round to nearest even
    function automatic logic [7:0] f32_to_fp8(input logic [31:0] x);
        logic [7:0]  sign;
        logic [7:0]  be;
        logic [30:0] mag;
        logic [23:0] mant;
        int          unb;
        int          sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        int          code;
        sign = x[31] ? 8'h80 : 8'h00;
        be = x[30:23];
        mag = x[30:0];
        if (be == 8'hFF || mag == 0) return 8'h00;
        if (mag >= 31'h43700000) return sign | 8'h77;  // |x| >= 240
        unb = int'(be) - 127;
        if (unb < -10) return sign;                     // underflow keeps its sign
        mant = {1'b1, x[22:0]};
        sh = (unb >= -6) ? 20 : 14 - unb;
        q = mant >> sh;
        rem = mant & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        code = (unb >= -6) ? (unb + 6) * 8 + int'(q) : int'(q);
        if (code > 'h77) code = 'h77;
        return sign | 8'(code);
    endfunction

    function automatic logic [15:0] fp8_to_half(input logic [7:0] v);
        logic [3:0] e;
        logic [2:0] m;
        e = v[6:3];
        m = v[2:0];
        if (v[6:0] == 7'd0) return {v[7], 15'd0};
        if (e == 4'hF) return {v[7], 5'd31, 10'd1};
        if (e == 4'd0) begin
            if (m[2]) return {v[7], 5'd8, m[1:0], 8'd0};
            if (m[1]) return {v[7], 5'd7, m[0], 9'd0};
            return {v[7], 5'd6, 10'd0};
        end
        return {v[7], 5'(e) + 5'd8, m, 7'd0};
    endfunction

    function automatic logic [31:0] predict_result(input req_t r);
        longint unsigned ma, mb, prod;
        longint          sa, sb, sum;
        bit              na, nb;
        ma = fp8_units(r.operand_a);
        mb = fp8_units(r.operand_b);
        na = fp8_neg(r.operand_a);
        nb = fp8_neg(r.operand_b);
        prod = ma * mb;
        sa = na ? -longint'(ma) : longint'(ma);
        sb = nb ? -longint'(mb) : longint'(mb);
        sum = sa + sb;
        case (r.opcode)
            OP_MUL:     return {24'd0, f32_to_fp8(units_to_f32(na ^ nb, prod, 18))};
            OP_ADD:     return {24'd0, f32_to_fp8(units_to_f32(sum < 0,
                                    longint'(sum < 0 ? -sum : sum), 9))};
            OP_MUL_F32: return units_to_f32(na ^ nb, prod, 18);
            OP_TO_F16:  return {16'd0, fp8_to_half(r.operand_a)};
            OP_ENCODE:  return {24'd0, f32_to_fp8(r.float_in)};
            OP_DECODE:  return units_to_f32(na, ma, 9);
            default:    return 32'd0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic req_t make_req(input logic [2:0] op, input logic [7:0] a,
                                      input logic [7:0] b, input logic [31:0] f);
        req_t r;
        r.opcode = op;
        r.operand_a = a;
        r.operand_b = b;
        r.float_in = f;
        return r;
    endfunction

    // float patterns clustered around the fp8 range, plus raw noise
    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 5))
            0, 1, 2: f[30:23] = 8'($urandom_range(112, 136));
            3:       f[22:0] = f[22:0] & ~(23'h7FFFFF >> $urandom_range(0, 23)); // short mantissa
            4:       f[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] rand_fp8();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 7) == 0) v[6:3] = $urandom_range(0, 1) ? 4'hF : 4'h0;
        return v;
    endfunction

    initial begin
        logic [2:0] op;
        // directed: extremes, every opcode, NaN, signed zeros, rounding ties,
        // saturation and underflow
        pending_reqs.push_back(make_req(OP_MUL, 8'h77, 8'h77, 32'h0));        // saturate
        pending_reqs.push_back(make_req(OP_MUL, 8'h01, 8'h81, 32'h0));        // negative underflow
        pending_reqs.push_back(make_req(OP_MUL, 8'h80, 8'h38, 32'h0));        // -0 times one
        pending_reqs.push_back(make_req(OP_MUL, 8'h7F, 8'hFF, 32'h0));        // NaN operands
        pending_reqs.push_back(make_req(OP_ADD, 8'h77, 8'h77, 32'h0));
        pending_reqs.push_back(make_req(OP_ADD, 8'h80, 8'h80, 32'h0));        // -0 + -0
        pending_reqs.push_back(make_req(OP_ADD, 8'h38, 8'hB8, 32'h0));        // cancel to zero
        pending_reqs.push_back(make_req(OP_ADD, 8'h01, 8'h07, 32'h0));        // subnormal carry
        pending_reqs.push_back(make_req(OP_MUL_F32, 8'h80, 8'h01, 32'h0));    // -0 product
        pending_reqs.push_back(make_req(OP_MUL_F32, 8'hF7, 8'h77, 32'h0));
        pending_reqs.push_back(make_req(OP_MUL_F32, 8'h01, 8'h01, 32'h0));    // smallest product
        pending_reqs.push_back(make_req(OP_TO_F16, 8'h80, 8'h00, 32'h0));
        pending_reqs.push_back(make_req(OP_TO_F16, 8'hFF, 8'h00, 32'h0));     // NaN
        pending_reqs.push_back(make_req(OP_TO_F16, 8'h05, 8'h00, 32'h0));     // subnormal
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'h7F800000));  // +inf
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'hFFC00001));  // NaN
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'h80000000));  // -0
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'h43700000));  // 240
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'h436FFFFF));  // just below
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'h3F880000));  // tie to even
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'hBA800000));  // -2^-10 tie
        pending_reqs.push_back(make_req(OP_ENCODE, 8'h0, 8'h0, 32'hBA800001));  // just past tie
        pending_reqs.push_back(make_req(OP_DECODE, 8'hFF, 8'h0, 32'h0));
        pending_reqs.push_back(make_req(OP_DECODE, 8'h80, 8'h0, 32'h0));
        pending_reqs.push_back(make_req(OP_SPARE6, 8'hFF, 8'hFF, 32'hFFFFFFFF));
        pending_reqs.push_back(make_req(OP_SPARE7, 8'h55, 8'hAA, 32'h12345678));

        for (int i = 0; i < RANDOM_REQS; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            pending_reqs.push_back(make_req(op, rand_fp8(), rand_fp8(), rand_float()));
        end

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid && expected_results.size() == 0);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps; the receiver
    // stalls in phases (always ready, coin flip, mostly stalled).
    // ------------------------------------------------------------------
    initial begin
        s_valid = 1'b0;
        s_opcode = '0;
        s_operand_a = '0;
        s_operand_b = '0;
        s_float_in = '0;
        m_ready = 1'b0;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && !req_taken) begin
                // hold the request until it is taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_t r;
                r = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_opcode <= r.opcode;
                s_operand_a <= r.operand_a;
                s_operand_b <= r.operand_b;
                s_float_in <= r.float_in;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end

            if (stall_phase == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_phase <= $urandom_range(5, 60);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted result.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [31:0] want;
        bit          s_fire;
        bit          m_fire;
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        req_taken <= s_fire;
        if (s_fire)
            expected_results.push_back(predict_result(make_req(s_opcode, s_operand_a,
                                                               s_operand_b, s_float_in)));
        if (m_fire) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: result actual %h", m_result);
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (m_result !== want) begin
                    $error("result mismatch: expected %h actual %h", want, m_result);
                    err_cnt++;
                end
            end
        end

        // watchdog
        if (!aresetn || s_fire || m_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
`default_nettype wire

### fp8_e4m3_arith_convert_unit_core.f
rtl/core/fp8e4_pkg.sv
rtl/core/fp8e4_arith.sv
rtl/core/fp8_e4m3_arith_convert_unit_core.sv
tb/sv/tb_fp8_e4m3_arith_convert_unit_core.sv
